FILE: sv/csr_sparse_matrix_vector_multiply_unit_defines.svh
// Assertion macros shared by the sparse matrix-vector multiply RTL.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define CSMV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csmv: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CSMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csmv: next-cycle check failed");

`else

`define CSMV_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CSMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/csmv_pkg.sv
// Types and constants of the sparse matrix-vector multiply unit.
`default_nettype none

package csmv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int ADDR_W       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;
    localparam int ROW_W   = 20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NONZERO = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END_ROW = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_MAC,
        OP_END
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [INDEX_W-1:0]  index;
        logic [VALUE_W-1:0]  value;
    } t_item;

endpackage

`default_nettype wire

FILE: sv/csmv_front.sv
// Front end: accepts input beats, decodes the command and drops no-op beats.
`default_nettype none

module csmv_front (
    input  wire logic                        i_valid,
    input  wire logic [csmv_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [csmv_pkg::INDEX_W-1:0] i_index,
    input  wire logic [csmv_pkg::VALUE_W-1:0] i_value,
    input  wire logic                        i_q_full,
    output logic                             o_ready,
    output logic                             o_push,
    output csmv_pkg::t_item                  o_item
);
    import csmv_pkg::*;

    logic in_range;
    logic keep;

    // Indexes past the vector store do nothing for loads or nonzeros.
    assign in_range = 32'(i_index) < 32'(VECTOR_DEPTH);

    always_comb begin
        o_item.index = i_index;
        o_item.value = i_value;
        o_item.op    = OP_END;
        keep         = 1'b0;
        unique case (i_cmd)
            CMD_LOAD: begin
                o_item.op = OP_LOAD;
                keep      = in_range;
            end
            CMD_NONZERO: begin
                o_item.op = OP_MAC;
                keep      = in_range;
            end
            CMD_END_ROW: begin
                o_item.op = OP_END;
                keep      = 1'b1;
            end
            default: begin
                // unknown command: accept and drop
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;

endmodule

`default_nettype wire

FILE: sv/csmv_queue.sv
// Short queue of decoded beats between the front and back ends.
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_unit_defines.svh"

module csmv_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire csmv_pkg::t_item i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output csmv_pkg::t_item      o_item
);
    import csmv_pkg::*;

    t_item               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    `CSMV_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, o_full, !i_push)
    `CSMV_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, !o_valid, !i_pop)
    `CSMV_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH))
endmodule

`default_nettype wire

FILE: sv/csmv_back.sv
// Back end: vector store, multiplier, saturating row accumulator, result register.
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_unit_defines.svh"

module csmv_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire csmv_pkg::t_item               i_q_item,
    output logic                               o_q_pop,
    input  wire logic                          i_ready,
    output logic                               o_valid,
    output logic signed [csmv_pkg::SUM_W-1:0]  o_y_value,
    output logic [csmv_pkg::ROW_W-1:0]         o_row_index,
    output logic                               o_saturated
);
    import csmv_pkg::*;

    logic [VALUE_W-1:0]        r_mem [VECTOR_DEPTH];
    logic [ADDR_W-1:0]         addr;
    logic                      adv;
    logic                      pop;

    logic                      r_s1_valid;
    t_op                       r_s1_op;
    logic signed [VALUE_W-1:0] r_s1_vec;
    logic signed [VALUE_W-1:0] r_s1_val;

    logic                      r_s2_valid;
    t_op                       r_s2_op;
    logic signed [SUM_W-1:0]   r_s2_prod;

    logic [SUM_W-1:0]          r_sum;
    logic                      r_ovf;
    logic [ROW_W-1:0]          r_row;
    logic [SUM_W-1:0]          n_sum;
    logic                      n_ovf;
    logic [SUM_W-1:0]          raw_sum;

    logic                      r_out_valid;
    logic [SUM_W-1:0]          r_out_sum;
    logic [ROW_W-1:0]          r_out_row;
    logic                      r_out_sat;

    // Hold the whole pipe only when a row end meets a full result register.
    assign adv  = !(r_s2_valid && (r_s2_op == OP_END) && r_out_valid && !i_ready);
    assign pop  = i_q_valid && adv;
    assign addr = ADDR_W'(i_q_item.index);
    assign o_q_pop = pop;

    // Vector store: written by loads, read by nonzeros, both at pop time.
    always_ff @(posedge i_clk) begin
        if (pop && (i_q_item.op == OP_LOAD)) begin
            r_mem[addr] <= i_q_item.value;
        end
        if (pop && (i_q_item.op == OP_MAC)) begin
            r_s1_vec <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op   <= i_q_item.op;
            r_s1_val  <= i_q_item.value;
            r_s2_op   <= r_s1_op;
            r_s2_prod <= SUM_W'(r_s1_vec) * SUM_W'(r_s1_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            // loads finish at the store; only nonzeros and row ends go on
            r_s1_valid <= pop && (i_q_item.op != OP_LOAD);
            r_s2_valid <= r_s1_valid;
        end
    end

    always_comb begin
        raw_sum = r_sum + r_s2_prod;
        n_sum   = raw_sum;
        n_ovf   = r_ovf;
        // clamp when both addends share a sign and the sum flips it
        if ((r_sum[SUM_W-1] == r_s2_prod[SUM_W-1]) && (raw_sum[SUM_W-1] != r_sum[SUM_W-1])) begin
            n_ovf = 1'b1;
            n_sum = r_sum[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ovf <= 1'b0;
            r_row <= '0;
        end else if (adv && r_s2_valid) begin
            unique case (r_s2_op)
                OP_MAC: begin
                    r_sum <= n_sum;
                    r_ovf <= n_ovf;
                end
                OP_END: begin
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                    r_row <= r_row + ROW_W'(1);
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s2_valid && (r_s2_op == OP_END)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && (r_s2_op == OP_END)) begin
            r_out_sum <= r_sum;
            r_out_row <= r_row;
            r_out_sat <= r_ovf;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_y_value   = r_out_sum;
    assign o_row_index = r_out_row;
    assign o_saturated = r_out_sat;

    `CSMV_ASSERT_NOW(a_no_pop_on_stall, i_clk, i_rst_n, !adv, !o_q_pop)
    `CSMV_ASSERT_NEXT(a_row_end_clears, i_clk, i_rst_n,
        adv && r_s2_valid && (r_s2_op == OP_END), (r_sum == '0) && !r_ovf && r_out_valid)
    `CSMV_ASSERT_NEXT(a_row_advances, i_clk, i_rst_n,
        adv && r_s2_valid && (r_s2_op == OP_END), r_row == $past(r_row) + ROW_W'(1))

endmodule

`default_nettype wire

FILE: sv/csr_sparse_matrix_vector_multiply_unit.sv
// A row-end beat reaches o_valid through the queue, the store read, the multiply and the
// accumulate/result register, in that order.
// Throughput: one beat per cycle, unless a row end meets an unread full result register.
// A 4-beat queue between decode and the pipe absorbs output stalls.
// Reset clears control, row sum, row counter and flag; the vector store keeps
// its contents and must be loaded before use, so no clearing pass runs.
`default_nettype none

module csr_sparse_matrix_vector_multiply_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [csmv_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [csmv_pkg::INDEX_W-1:0]    i_index,
    input  wire logic signed [csmv_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [csmv_pkg::SUM_W-1:0]    o_y_value,
    output logic [csmv_pkg::ROW_W-1:0]           o_row_index,
    output logic                                o_saturated
);
    import csmv_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    t_item push_item;
    t_item q_item;

    csmv_front u_front (
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .i_index  (i_index),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (push),
        .o_item   (push_item)
    );

    csmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    csmv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (pop),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_y_value   (o_y_value),
        .o_row_index (o_row_index),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire

FILE: tb/tb_csr_sparse_matrix_vector_multiply_unit.sv
// Self-checking testbench for the CSR sparse matrix-vector multiply unit.
`default_nettype none

module tb_csr_sparse_matrix_vector_multiply_unit;

    import csmv_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int               DRAIN_CYCLES = 8;
    localparam longint           CYCLE_LIMIT  = 5_000_000;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [SUM_W-1:0] y_value;
        logic [ROW_W-1:0]        row_index;
        logic                    saturated;
    } t_row_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [CMD_W-1:0]            i_cmd;
    logic [INDEX_W-1:0]          i_index;
    logic signed [VALUE_W-1:0]   i_value;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic signed [SUM_W-1:0]     o_y_value;
    logic [ROW_W-1:0]            o_row_index;
    logic                        o_saturated;

    // Shadow copy of the block state
    logic signed [VALUE_W-1:0]   vec_copy [VECTOR_DEPTH];
    bit                          vec_loaded [VECTOR_DEPTH];
    logic [INDEX_W-1:0]          loaded_cols[$];
    logic signed [SUM_W-1:0]     row_acc;
    logic [ROW_W-1:0]            row_num;
    logic                        row_sat;

    t_row_result                 pending_rows[$];

    int     fail_count;
    int     beats_sent;
    int     src_idle_pct;
    int     sink_stall_pct;
    int     hold_cycles;
    longint cycle_count;

    csr_sparse_matrix_vector_multiply_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_y_value   (o_y_value),
        .o_row_index (o_row_index),
        .o_saturated (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("csr_sparse_matrix_vector_multiply_unit test failed");
            $finish;
        end
    end

    // Receiver: a hold-off stretch overrides the random stall rate
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready = 1'b0;
            hold_cycles--;
        end else begin
            i_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare every accepted row result against the oldest expectation
    always @(posedge i_clk) begin
        t_row_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected row result: row_index %0d y_value %0d",
                       o_row_index, o_y_value);
                fail_count++;
            end else begin
                want = pending_rows.pop_front();
                if (o_y_value !== want.y_value) begin
                    $error("y_value mismatch: expected %0d, got %0d",
                           want.y_value, o_y_value);
                    fail_count++;
                end
                if (o_row_index !== want.row_index) begin
                    $error("row_index mismatch: expected %0d, got %0d",
                           want.row_index, o_row_index);
                    fail_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated mismatch: expected %0d, got %0d",
                           want.saturated, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    // Update the shadow state with one accepted beat; a row end queues its result
    task automatic accumulate_beat(input logic [CMD_W-1:0] cmd,
                                   input logic [INDEX_W-1:0] idx,
                                   input logic signed [VALUE_W-1:0] val);
        logic signed [SUM_W-1:0] prod;
        logic signed [SUM_W-1:0] sum;
        t_row_result             done;
        case (cmd)
            CMD_LOAD: begin
                if (!vec_loaded[idx]) begin
                    vec_loaded[idx] = 1'b1;
                    loaded_cols.push_back(idx);
                end
                vec_copy[idx] = val;
            end
            CMD_NONZERO: begin
                prod = SUM_W'(vec_copy[idx]) * SUM_W'(val);
                sum  = row_acc + prod;
                // Clamp when both addends share a sign that the sum lost
                if (row_acc[SUM_W-1] == prod[SUM_W-1] && sum[SUM_W-1] != row_acc[SUM_W-1]) begin
                    row_sat = 1'b1;
                    sum     = row_acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
                end
                row_acc = sum;
            end
            CMD_END_ROW: begin
                done.y_value   = row_acc;
                done.row_index = row_num;
                done.saturated = row_sat;
                pending_rows.push_back(done);
                row_acc = '0;
                row_sat = 1'b0;
                row_num = row_num + ROW_W'(1);
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [CMD_W-1:0] cmd,
                             input logic [INDEX_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_cmd   = cmd;
        i_index = idx;
        i_value = val;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        accumulate_beat(cmd, idx, val);
        if (cmd != CMD_UNKNOWN)
            beats_sent++;
    endtask

    // Drop valid, wait until every row result is back, then let the pipe settle
    task automatic drain_results;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_rows.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_q16;
        logic [VALUE_W-1:0] raw;
        case ($urandom_range(3))
            0: raw = $urandom;
            1: raw = $urandom_range(32'h3FFFF) - 32'h1FFFF;
            2: begin
                case ($urandom_range(3))
                    0: raw = 32'h8000_0000;
                    1: raw = 32'h7FFF_FFFF;
                    2: raw = 32'h0000_0000;
                    default: raw = 32'hFFFF_FFFF;
                endcase
            end
            default: raw = {{8{$urandom_range(1) == 1}}, 24'($urandom)};
        endcase
        return raw;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_loaded_col;
        return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
    endfunction

    task automatic test_directed_cases;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_beat(CMD_END_ROW, 10'h000, 32'sh0);                 // empty row
        send_beat(CMD_LOAD, 10'h000, 32'sh8000_0000);
        send_beat(CMD_LOAD, 10'h3FF, 32'sh7FFF_FFFF);
        send_beat(CMD_LOAD, 10'h155, 32'sh0001_0000);
        send_beat(CMD_LOAD, 10'h2AA, 32'shFFFF_FFFF);
        send_beat(CMD_UNKNOWN, 10'h3FF, 32'shDEAD_BEEF);         // ignored
        send_beat(CMD_NONZERO, 10'h155, 32'sh0001_8000);
        send_beat(CMD_NONZERO, 10'h2AA, 32'sh7FFF_FFFF);
        send_beat(CMD_END_ROW, 10'h2AA, 32'shFFFF_FFFF);
        // Positive overflow, then keep adding from the clamped value
        send_beat(CMD_NONZERO, 10'h000, 32'sh8000_0000);
        send_beat(CMD_NONZERO, 10'h000, 32'sh8000_0000);
        send_beat(CMD_NONZERO, 10'h000, 32'sh8000_0000);
        send_beat(CMD_NONZERO, 10'h3FF, 32'sh8000_0000);
        send_beat(CMD_END_ROW, 10'h155, 32'sh0);
        // Negative overflow
        send_beat(CMD_NONZERO, 10'h000, 32'sh7FFF_FFFF);
        send_beat(CMD_NONZERO, 10'h000, 32'sh7FFF_FFFF);
        send_beat(CMD_NONZERO, 10'h000, 32'sh7FFF_FFFF);
        send_beat(CMD_END_ROW, 10'h000, 32'sh0);
        // Flag clears on the next row
        send_beat(CMD_NONZERO, 10'h155, 32'sh0);
        send_beat(CMD_NONZERO, 10'h3FF, 32'sh7FFF_FFFF);
        send_beat(CMD_END_ROW, 10'h3FF, 32'sh7FFF_FFFF);
        drain_results;
    endtask

    task automatic send_saturating_row;
        logic [INDEX_W-1:0] col;
        int                 n_nz;
        col  = INDEX_W'($urandom_range(VECTOR_DEPTH - 1));
        n_nz = $urandom_range(3, 6);
        send_beat(CMD_LOAD, col, $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        repeat (n_nz) begin
            if ($urandom_range(4) == 0)
                send_beat(CMD_NONZERO, col, pick_q16());
            else
                send_beat(CMD_NONZERO, col,
                          $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        end
        send_beat(CMD_END_ROW, INDEX_W'($urandom), $urandom);
    endtask

    task automatic test_random_rows(input int n_beats, input int idle_pct,
                                    input int stall_pct);
        int start;
        int pick;
        int n_nz;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        start          = beats_sent;
        while (beats_sent - start < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 4))
                    send_beat(CMD_LOAD, INDEX_W'($urandom), pick_q16());
            end else if (pick < 15) begin
                send_beat(CMD_UNKNOWN, INDEX_W'($urandom), $urandom);
            end else if (pick < 20) begin
                send_beat(CMD_END_ROW, INDEX_W'($urandom), $urandom);
            end else if (pick < 28) begin
                send_saturating_row();
            end else begin
                n_nz = $urandom_range(0, 7);
                repeat (n_nz)
                    send_beat(CMD_NONZERO, pick_loaded_col(), pick_q16());
                send_beat(CMD_END_ROW, INDEX_W'($urandom), $urandom);
            end
        end
        drain_results;
    endtask

    // Hold the receiver off while beats keep coming, so the input stalls
    task automatic test_output_backpressure;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_cycles    = 200;
        repeat (16) begin
            send_beat(CMD_NONZERO, pick_loaded_col(), pick_q16());
            send_beat(CMD_NONZERO, pick_loaded_col(), pick_q16());
            send_beat(CMD_END_ROW, INDEX_W'($urandom), $urandom);
        end
        drain_results;
        repeat (6) begin
            send_beat(CMD_NONZERO, pick_loaded_col(), pick_q16());
            send_beat(CMD_END_ROW, INDEX_W'($urandom), $urandom);
        end
        drain_results;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = CMD_LOAD;
        i_index        = '0;
        i_value        = '0;
        row_acc        = '0;
        row_num        = '0;
        row_sat        = 1'b0;
        fail_count     = 0;
        beats_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_cycles    = 0;
        cycle_count    = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_rows(340, 0, 0);
        test_random_rows(340, 80, 0);
        test_random_rows(340, 0, 80);
        test_random_rows(340, 19, 19);
        test_output_backpressure();

        if (fail_count == 0)
            $display("csr_sparse_matrix_vector_multiply_unit test passed");
        else
            $display("csr_sparse_matrix_vector_multiply_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/csmv_pkg.sv
sv/csmv_front.sv
sv/csmv_queue.sv
sv/csmv_back.sv
sv/csr_sparse_matrix_vector_multiply_unit.sv
tb/tb_csr_sparse_matrix_vector_multiply_unit.sv
